FILE: rtl/fsr_pkg.sv
// Shared types, codes and port widths for the frame slot ring manager.
// No dependencies; every other file of the block uses this package.
package fsr_pkg;

	// default configuration
	localparam int SLOT_COUNT_DEF = 3;
	localparam int GEN_BITS_DEF   = 48;
	localparam int DIM_BITS_DEF   = 16;

	// fixed field widths at the channel boundary
	localparam int REQ_W  = 2;
	localparam int IDX_W  = 2;
	localparam int PDIM_W = 16;
	localparam int PGEN_W = 48;
	localparam int STAT_W = 3;
	localparam int DROP_W = 32;

	// reader count per slot
	localparam int                 COUNT_W     = 8;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'd255;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_BEGIN_WR = 2'd0;
	localparam logic [REQ_W-1:0] REQ_END_WR   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ACQUIRE  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_MATCH = 3'd3;
	localparam logic [STAT_W-1:0] ST_LIMIT    = 3'd4;

	// write enables into the slot file
	typedef struct packed {
		logic count_en;
		logic gen_en;
		logic dim_en;
	} slot_wr_t;

	// one result item
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  granted_slot;
		logic [PDIM_W-1:0] out_width;
		logic [PDIM_W-1:0] out_height;
		logic [PGEN_W-1:0] out_generation;
		logic [PGEN_W-1:0] latest_generation;
		logic [DROP_W-1:0] drop_count;
	} rsp_t;

endpackage

FILE: rtl/fsr_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on fsr_pkg for the field widths.
interface fsr_req_if;
	logic                       valid;
	logic                       ready;
	logic [fsr_pkg::REQ_W-1:0]  req_type;
	logic [fsr_pkg::IDX_W-1:0]  slot_index;
	logic [fsr_pkg::PDIM_W-1:0] frame_width;
	logic [fsr_pkg::PDIM_W-1:0] frame_height;
	logic [fsr_pkg::PGEN_W-1:0] release_generation;

	modport source (output valid, req_type, slot_index, frame_width, frame_height,
		release_generation, input ready);
	modport sink (input valid, req_type, slot_index, frame_width, frame_height,
		release_generation, output ready);
endinterface

interface fsr_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [fsr_pkg::STAT_W-1:0] status;
	logic [fsr_pkg::IDX_W-1:0]  granted_slot;
	logic [fsr_pkg::PDIM_W-1:0] out_width;
	logic [fsr_pkg::PDIM_W-1:0] out_height;
	logic [fsr_pkg::PGEN_W-1:0] out_generation;
	logic [fsr_pkg::PGEN_W-1:0] latest_generation;
	logic [fsr_pkg::DROP_W-1:0] drop_count;

	modport source (output valid, status, granted_slot, out_width, out_height,
		out_generation, latest_generation, drop_count, input ready);
	modport sink (input valid, status, granted_slot, out_width, out_height,
		out_generation, latest_generation, drop_count, output ready);
endinterface

FILE: rtl/fsr_slot_file.sv
// Per-slot state: reader count, generation and frame size, one read port, one write port.
// Depends on fsr_pkg.
module fsr_slot_file #(
	parameter int SLOT_COUNT = fsr_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = fsr_pkg::GEN_BITS_DEF,
	parameter int DIM_BITS   = fsr_pkg::DIM_BITS_DEF,
	localparam int SLOT_W    = $clog2(SLOT_COUNT)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [SLOT_W-1:0]            rd_idx,
	output logic [fsr_pkg::COUNT_W-1:0]  rd_count,
	output logic [GEN_BITS-1:0]          rd_gen,
	output logic [DIM_BITS-1:0]          rd_width,
	output logic [DIM_BITS-1:0]          rd_height,
	input  fsr_pkg::slot_wr_t            wr_ctl,
	input  logic [SLOT_W-1:0]            wr_idx,
	input  logic [fsr_pkg::COUNT_W-1:0]  wr_count,
	input  logic [GEN_BITS-1:0]          wr_gen,
	input  logic [DIM_BITS-1:0]          wr_width,
	input  logic [DIM_BITS-1:0]          wr_height
);
	import fsr_pkg::*;

	logic [COUNT_W-1:0]  count_q  [SLOT_COUNT];
	logic [GEN_BITS-1:0] gen_q    [SLOT_COUNT];
	logic [DIM_BITS-1:0] width_q  [SLOT_COUNT];
	logic [DIM_BITS-1:0] height_q [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				count_q[i]  <= '0;
				gen_q[i]    <= '0;
				width_q[i]  <= '0;
				height_q[i] <= '0;
			end
		end else begin
			if (wr_ctl.count_en) begin
				count_q[wr_idx] <= wr_count;
			end
			if (wr_ctl.gen_en) begin
				gen_q[wr_idx] <= wr_gen;
			end
			if (wr_ctl.dim_en) begin
				width_q[wr_idx]  <= wr_width;
				height_q[wr_idx] <= wr_height;
			end
		end
	end

	assign rd_count  = count_q[rd_idx];
	assign rd_gen    = gen_q[rd_idx];
	assign rd_width  = width_q[rd_idx];
	assign rd_height = height_q[rd_idx];

endmodule

FILE: rtl/fsr_ctrl.sv
// Request sequencer: scans the slot file one slot a cycle through a shared compare unit,
// then applies the update and hands the result on. Depends on fsr_pkg and fsr_if.
module fsr_ctrl #(
	parameter int SLOT_COUNT = fsr_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = fsr_pkg::GEN_BITS_DEF,
	parameter int DIM_BITS   = fsr_pkg::DIM_BITS_DEF,
	localparam int SLOT_W    = $clog2(SLOT_COUNT)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	fsr_req_if.sink                      req,
	output logic                         res_valid,
	input  logic                         res_ready,
	output fsr_pkg::rsp_t                res,
	output logic [SLOT_W-1:0]            rd_idx,
	input  logic [fsr_pkg::COUNT_W-1:0]  rd_count,
	input  logic [GEN_BITS-1:0]          rd_gen,
	input  logic [DIM_BITS-1:0]          rd_width,
	input  logic [DIM_BITS-1:0]          rd_height,
	output fsr_pkg::slot_wr_t            wr_ctl,
	output logic [SLOT_W-1:0]            wr_idx,
	output logic [fsr_pkg::COUNT_W-1:0]  wr_count,
	output logic [GEN_BITS-1:0]          wr_gen,
	output logic [DIM_BITS-1:0]          wr_width,
	output logic [DIM_BITS-1:0]          wr_height
);
	import fsr_pkg::*;

	localparam int CMP_W = (GEN_BITS > PGEN_W) ? GEN_BITS : PGEN_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t              state_q;
	logic [REQ_W-1:0]    rtype_q;
	logic [IDX_W-1:0]    ridx_q;
	logic [PDIM_W-1:0]   rwidth_q;
	logic [PDIM_W-1:0]   rheight_q;
	logic [PGEN_W-1:0]   rgen_q;
	logic [SLOT_W-1:0]   scan_q;
	logic [SLOT_W-1:0]   hit_idx_q;
	logic                hit_q;
	logic                lim_q;
	logic [SLOT_W-1:0]   shown_slot_q;
	logic                shown_valid_q;
	logic [GEN_BITS-1:0] gen_ctr_q;
	logic [GEN_BITS-1:0] latest_q;
	logic [DROP_W-1:0]   drops_q;

	logic                is_shown;
	logic                free_ok;
	logic                match_ok;
	logic                idx_ok;
	logic                acq_nothing;
	logic                acq_limit;
	logic                step_hit;
	logic                one_shot;
	logic                step_done;
	logic                commit;
	logic [GEN_BITS-1:0] gen_inc;
	logic [GEN_BITS-1:0] gen_nx;
	logic [GEN_BITS-1:0] latest_nx;
	logic [DROP_W-1:0]   drops_nx;

	assign req.ready = (state_q == S_IDLE);

	// shared compare unit, reused on every scan step
	assign is_shown    = shown_valid_q && (scan_q == shown_slot_q);
	assign free_ok     = !is_shown && (rd_count == '0);
	assign match_ok    = (rgen_q != '0) && (CMP_W'(rd_gen) == CMP_W'(rgen_q))
		&& (rd_count != '0);
	assign idx_ok      = ({{SLOT_W{1'b0}}, ridx_q} < (SLOT_W + IDX_W)'(SLOT_COUNT));
	assign acq_nothing = !shown_valid_q || (rd_gen == '0);
	assign acq_limit   = (rd_count >= COUNT_LIMIT);
	assign one_shot    = (rtype_q == REQ_END_WR) || (rtype_q == REQ_ACQUIRE);

	always_comb begin
		case (rtype_q)
			REQ_BEGIN_WR: step_hit = free_ok;
			REQ_END_WR:   step_hit = idx_ok;
			REQ_ACQUIRE:  step_hit = !acq_nothing && !acq_limit;
			REQ_RELEASE:  step_hit = match_ok;
			default:      step_hit = 1'b0;
		endcase
	end

	assign step_done = one_shot || step_hit || (scan_q == LAST_SLOT);

	always_comb begin
		case (state_q)
			S_SCAN:   rd_idx = (rtype_q == REQ_ACQUIRE) ? shown_slot_q : scan_q;
			S_FINISH: rd_idx = hit_idx_q;
			default:  rd_idx = scan_q;
		endcase
	end

	// generation counter wraps within its width and skips zero
	assign gen_inc = GEN_BITS'(gen_ctr_q + GEN_BITS'(1));
	assign gen_nx  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

	assign latest_nx = ((rtype_q == REQ_END_WR) && hit_q) ? gen_ctr_q : latest_q;
	assign drops_nx  = ((rtype_q == REQ_BEGIN_WR) && !hit_q)
		? DROP_W'(drops_q + DROP_W'(1)) : drops_q;

	assign res_valid = (state_q == S_FINISH);
	assign commit    = res_valid && res_ready;

	// slot update, applied only on the cycle the result is handed on
	always_comb begin
		wr_ctl    = '0;
		wr_idx    = hit_idx_q;
		wr_count  = '0;
		wr_gen    = '0;
		wr_width  = DIM_BITS'(rwidth_q);
		wr_height = DIM_BITS'(rheight_q);
		if (commit && hit_q) begin
			wr_ctl.count_en = 1'b1;
			case (rtype_q)
				REQ_BEGIN_WR: begin
					wr_count      = COUNT_W'(1);
					wr_ctl.gen_en = 1'b1;
				end
				REQ_END_WR: begin
					wr_gen        = gen_ctr_q;
					wr_ctl.gen_en = 1'b1;
					wr_ctl.dim_en = 1'b1;
				end
				REQ_ACQUIRE: wr_count = COUNT_W'(rd_count + COUNT_W'(1));
				REQ_RELEASE: wr_count = COUNT_W'(rd_count - COUNT_W'(1));
				default:     wr_ctl   = '0;
			endcase
		end
	end

	always_comb begin
		res                   = '0;
		res.latest_generation = PGEN_W'(CMP_W'(latest_nx));
		res.drop_count        = drops_nx;
		case (rtype_q)
			REQ_BEGIN_WR: begin
				res.status = hit_q ? ST_OK : ST_NO_FREE;
				if (hit_q) begin
					res.granted_slot = IDX_W'(hit_idx_q);
				end
			end
			REQ_END_WR:  res.status = hit_q ? ST_OK : ST_NO_MATCH;
			REQ_ACQUIRE: begin
				if (hit_q) begin
					res.status         = ST_OK;
					res.granted_slot   = IDX_W'(hit_idx_q);
					res.out_width      = PDIM_W'(rd_width);
					res.out_height     = PDIM_W'(rd_height);
					res.out_generation = PGEN_W'(CMP_W'(rd_gen));
				end else begin
					res.status = lim_q ? ST_LIMIT : ST_NOTHING;
				end
			end
			REQ_RELEASE: res.status = hit_q ? ST_OK : ST_NO_MATCH;
			default:     res.status = ST_NO_MATCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scan_q        <= '0;
			hit_idx_q     <= '0;
			hit_q         <= 1'b0;
			lim_q         <= 1'b0;
			shown_slot_q  <= '0;
			shown_valid_q <= 1'b0;
			gen_ctr_q     <= GEN_BITS'(1);
			latest_q      <= '0;
			drops_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (step_done) begin
						hit_q   <= step_hit;
						lim_q   <= !acq_nothing && acq_limit;
						state_q <= S_FINISH;
						if (rtype_q == REQ_END_WR) begin
							hit_idx_q <= SLOT_W'(ridx_q);
						end else if (rtype_q == REQ_ACQUIRE) begin
							hit_idx_q <= shown_slot_q;
						end else begin
							hit_idx_q <= scan_q;
						end
					end else begin
						scan_q <= scan_q + SLOT_W'(1);
					end
				end
				S_FINISH: begin
					// hold until the output register can take the result
					if (res_ready) begin
						latest_q <= latest_nx;
						drops_q  <= drops_nx;
						if ((rtype_q == REQ_END_WR) && hit_q) begin
							shown_slot_q  <= hit_idx_q;
							shown_valid_q <= 1'b1;
							gen_ctr_q     <= gen_nx;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload, captured on transfer
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			rtype_q   <= req.req_type;
			ridx_q    <= req.slot_index;
			rwidth_q  <= req.frame_width;
			rheight_q <= req.frame_height;
			rgen_q    <= req.release_generation;
		end
	end

endmodule

FILE: rtl/frame_slot_ring_manager.sv
// Top level of the frame slot ring manager: sequencer, slot file and result register.
// Depends on fsr_pkg, fsr_if, fsr_slot_file and fsr_ctrl.
//
//  channel | role   | carries
//  req     | sink   | req_type, slot_index, frame_width, frame_height, release_generation
//  rsp     | source | status, granted_slot, out_width, out_height, out_generation,
//          |        | latest_generation, drop_count
//
// Flow: end write and acquire pass through a single scan step to the result; begin write and
// release scan until a slot matches or the last slot is reached, as the single compare
// unit looks at one slot of the slot file a cycle.
// Reset: arst_n clears all slot state at once; a request is accepted on the next edge.
// Stalls: a held result sits in the output register while the next request is taken;
// the sequencer holds in its final step until that register is free.
module frame_slot_ring_manager #(
	parameter int SLOT_COUNT = fsr_pkg::SLOT_COUNT_DEF,
	parameter int GEN_BITS   = fsr_pkg::GEN_BITS_DEF,
	parameter int DIM_BITS   = fsr_pkg::DIM_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	fsr_req_if.sink   req,
	fsr_rsp_if.source rsp
);
	import fsr_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);

	logic                res_valid;
	logic                res_ready;
	rsp_t                res;
	logic [SLOT_W-1:0]   rd_idx;
	logic [COUNT_W-1:0]  rd_count;
	logic [GEN_BITS-1:0] rd_gen;
	logic [DIM_BITS-1:0] rd_width;
	logic [DIM_BITS-1:0] rd_height;
	slot_wr_t            wr_ctl;
	logic [SLOT_W-1:0]   wr_idx;
	logic [COUNT_W-1:0]  wr_count;
	logic [GEN_BITS-1:0] wr_gen;
	logic [DIM_BITS-1:0] wr_width;
	logic [DIM_BITS-1:0] wr_height;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	fsr_ctrl #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS),
		.DIM_BITS   (DIM_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_idx    (rd_idx),
		.rd_count  (rd_count),
		.rd_gen    (rd_gen),
		.rd_width  (rd_width),
		.rd_height (rd_height),
		.wr_ctl    (wr_ctl),
		.wr_idx    (wr_idx),
		.wr_count  (wr_count),
		.wr_gen    (wr_gen),
		.wr_width  (wr_width),
		.wr_height (wr_height)
	);

	fsr_slot_file #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS),
		.DIM_BITS   (DIM_BITS)
	) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.rd_count  (rd_count),
		.rd_gen    (rd_gen),
		.rd_width  (rd_width),
		.rd_height (rd_height),
		.wr_ctl    (wr_ctl),
		.wr_idx    (wr_idx),
		.wr_count  (wr_count),
		.wr_gen    (wr_gen),
		.wr_width  (wr_width),
		.wr_height (wr_height)
	);

	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_q.status;
	assign rsp.granted_slot      = rsp_q.granted_slot;
	assign rsp.out_width         = rsp_q.out_width;
	assign rsp.out_height        = rsp_q.out_height;
	assign rsp.out_generation    = rsp_q.out_generation;
	assign rsp.latest_generation = rsp_q.latest_generation;
	assign rsp.drop_count        = rsp_q.drop_count;

endmodule

FILE: verif/tb_frame_slot_ring_manager.sv
`timescale 1ns / 1ps
// Self-checking bench for frame_slot_ring_manager: random and directed slot requests,
// a slot table predictor updated on each request transfer and a scoreboard on the result channel.
// Depends on fsr_pkg, fsr_if and the RTL of the block.
module tb_frame_slot_ring_manager;
	import fsr_pkg::*;

	localparam int N_SLOTS      = SLOT_COUNT_DEF;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASE_LEN    = 120;
	localparam int STALL_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 20;
	localparam int BURST_LEN    = 260;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [IDX_W-1:0]  slot;
		logic [PDIM_W-1:0] width;
		logic [PDIM_W-1:0] height;
		logic [PGEN_W-1:0] gen;
	} frame_req_t;

	logic clk;
	logic arst_n;

	fsr_req_if req_ch ();
	fsr_rsp_if rsp_ch ();

	frame_slot_ring_manager dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// slot table as the block should hold it
	logic [COUNT_W-1:0] rd_cnt  [N_SLOTS];
	logic [PGEN_W-1:0]  gen_of  [N_SLOTS];
	logic [PDIM_W-1:0]  wid_of  [N_SLOTS];
	logic [PDIM_W-1:0]  hgt_of  [N_SLOTS];
	logic [IDX_W-1:0]   pub_slot;
	logic               pub_valid;
	logic [PGEN_W-1:0]  gen_next;
	logic [PGEN_W-1:0]  last_pub;
	logic [DROP_W-1:0]  drop_total;

	frame_req_t  pending_reqs [$];
	rsp_t        due_responses [$];
	logic [PGEN_W-1:0] issued_gen;
	int          n_queued;
	int          bursts;
	int          mismatches;
	int          req_taken_total;
	int          stall_cycles;
	bit          req_xfer;

	function automatic rsp_t slot_table_update(input frame_req_t it);
		rsp_t r;
		bit   found;
		int   s;
		r = '0;
		r.status = ST_OK;
		found = 1'b0;
		case (it.kind)
			REQ_BEGIN_WR: begin
				for (s = 0; s < N_SLOTS; s++) begin
					if (!found && !(pub_valid && pub_slot == IDX_W'(s)) && rd_cnt[s] == '0) begin
						found = 1'b1;
						rd_cnt[s] = COUNT_W'(1);
						gen_of[s] = '0;
						r.granted_slot = IDX_W'(s);
					end
				end
				if (!found) begin
					drop_total = drop_total + 1'b1;
					r.status = ST_NO_FREE;
				end
			end
			REQ_END_WR: begin
				if (int'(it.slot) < N_SLOTS) begin
					wid_of[it.slot] = it.width;
					hgt_of[it.slot] = it.height;
					gen_of[it.slot] = gen_next;
					rd_cnt[it.slot] = '0;
					pub_slot = it.slot;
					pub_valid = 1'b1;
					last_pub = gen_next;
					gen_next = gen_next + 1'b1;
					if (gen_next == '0)
						gen_next = PGEN_W'(1);
				end else begin
					r.status = ST_NO_MATCH;
				end
			end
			REQ_ACQUIRE: begin
				if (!pub_valid || gen_of[pub_slot] == '0) begin
					r.status = ST_NOTHING;
				end else if (rd_cnt[pub_slot] >= COUNT_LIMIT) begin
					r.status = ST_LIMIT;
				end else begin
					rd_cnt[pub_slot] = rd_cnt[pub_slot] + 1'b1;
					r.granted_slot   = pub_slot;
					r.out_width      = wid_of[pub_slot];
					r.out_height     = hgt_of[pub_slot];
					r.out_generation = gen_of[pub_slot];
				end
			end
			default: begin
				r.status = ST_NO_MATCH;
				// generation zero marks an unfinished slot and never matches
				if (it.gen != '0) begin
					for (s = 0; s < N_SLOTS; s++) begin
						if (!found && gen_of[s] == it.gen && rd_cnt[s] != '0) begin
							found = 1'b1;
							rd_cnt[s] = rd_cnt[s] - 1'b1;
							r.status = ST_OK;
						end
					end
				end
			end
		endcase
		r.latest_generation = last_pub;
		r.drop_count = drop_total;
		return r;
	endfunction

	function automatic logic [PGEN_W-1:0] rand_gen();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[PGEN_W-1:0];
	endfunction

	function automatic logic [PDIM_W-1:0] pick_dim();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PDIM_W'($urandom());
		endcase
	endfunction

	// one of the last few generations handed out, never zero
	function automatic logic [PGEN_W-1:0] recent_gen();
		logic [PGEN_W-1:0] g;
		g = issued_gen - PGEN_W'($urandom_range(1, 4));
		if (g == '0 || g >= issued_gen)
			g = PGEN_W'(1);
		return g;
	endfunction

	task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] slot,
		input logic [PDIM_W-1:0] w, input logic [PDIM_W-1:0] h, input logic [PGEN_W-1:0] g);
		frame_req_t it;
		it.kind   = kind;
		it.slot   = slot;
		it.width  = w;
		it.height = h;
		it.gen    = g;
		pending_reqs.push_back(it);
		n_queued++;
		if (kind == REQ_END_WR && int'(slot) < N_SLOTS)
			issued_gen++;
	endtask

	task automatic fill_directed();
		queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
		queue_req(REQ_RELEASE, 0, 0, 0, '0);
		queue_req(REQ_RELEASE, 0, 0, 0, 1);
		queue_req(REQ_END_WR, 3, '1, '1, '1);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_END_WR, 1, '1, '0, 0);
		queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
		queue_req(REQ_RELEASE, 0, 0, 0, 1);
		queue_req(REQ_RELEASE, 0, 0, 0, 1);
		queue_req(REQ_END_WR, 0, '0, '1, 0);
		queue_req(REQ_END_WR, 2, pick_dim(), pick_dim(), 0);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
		queue_req(REQ_RELEASE, 0, 0, 0, '1);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
		queue_req(REQ_END_WR, 3, '1, '1, 0);
		queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
		queue_req(REQ_RELEASE, 0, 0, 0, recent_gen());
	endtask

	task automatic fill_random();
		int pick;
		int k;
		int target;
		target = n_queued + RANDOM_ITEMS;
		while (n_queued < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// write a frame, then let a few readers at it
				queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
				queue_req(REQ_END_WR, ($urandom_range(0, 7) == 0) ? 2'd3 :
					IDX_W'($urandom_range(0, N_SLOTS - 1)), pick_dim(), pick_dim(), 0);
				for (k = $urandom_range(0, 3); k > 0; k--)
					queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
			end else if (pick < 65) begin
				queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
				queue_req(REQ_RELEASE, 0, 0, 0, recent_gen());
			end else if (pick < 75) begin
				queue_req(REQ_RELEASE, 0, 0, 0, recent_gen());
			end else if (pick < 82) begin
				// hand back generation zero, which never matches
				queue_req(REQ_RELEASE, 0, 0, 0, '0);
			end else if (pick < 85 && bursts < 2) begin
				// run the published frame up to the borrow limit and past it
				bursts++;
				for (k = 0; k < BURST_LEN; k++)
					queue_req(REQ_ACQUIRE, 0, 0, 0, 0);
				for (k = 0; k < 6; k++)
					queue_req(REQ_RELEASE, 0, 0, 0, issued_gen - 1'b1);
			end else begin
				queue_req(REQ_BEGIN_WR, 0, 0, 0, 0);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h at %0t", name, exp_v, act_v,
					$realtime);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: hold an item until its transfer, then take the next one or idle
	always @(negedge clk) begin
		int send_pct;
		int recv_pct;
		frame_req_t it;
		case ((req_taken_total / PHASE_LEN) % 4)
			0: begin send_pct = 0;  recv_pct = 0;  end
			1: begin send_pct = 65; recv_pct = 0;  end
			2: begin send_pct = 0;  recv_pct = 65; end
			default: begin send_pct = 15; recv_pct = 15; end
		endcase
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_pct);
			if (!req_ch.valid || req_xfer) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
					it = pending_reqs.pop_front();
					req_ch.req_type           <= it.kind;
					req_ch.slot_index         <= it.slot;
					req_ch.frame_width        <= it.width;
					req_ch.frame_height       <= it.height;
					req_ch.release_generation <= it.gen;
					req_ch.valid              <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: score results, predict on each request transfer, watch for a hang
	always @(posedge clk) begin
		frame_req_t seen;
		rsp_t       want;
		req_xfer = 1'b0;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with nothing outstanding at %0t", $realtime);
				end else begin
					want = due_responses.pop_front();
					check_field("status", want.status, rsp_ch.status);
					check_field("granted_slot", want.granted_slot, rsp_ch.granted_slot);
					check_field("out_width", want.out_width, rsp_ch.out_width);
					check_field("out_height", want.out_height, rsp_ch.out_height);
					check_field("out_generation", want.out_generation, rsp_ch.out_generation);
					check_field("latest_generation", want.latest_generation,
						rsp_ch.latest_generation);
					check_field("drop_count", want.drop_count, rsp_ch.drop_count);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.kind   = req_ch.req_type;
				seen.slot   = req_ch.slot_index;
				seen.width  = req_ch.frame_width;
				seen.height = req_ch.frame_height;
				seen.gen    = req_ch.release_generation;
				due_responses.push_back(slot_table_update(seen));
				req_taken_total++;
				req_xfer = 1'b1;
			end
			if (req_xfer || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int s;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_BEGIN_WR;
		req_ch.slot_index = '0;
		req_ch.frame_width = '0;
		req_ch.frame_height = '0;
		req_ch.release_generation = '0;
		rsp_ch.ready = 1'b0;
		for (s = 0; s < N_SLOTS; s++) begin
			rd_cnt[s] = '0;
			gen_of[s] = '0;
			wid_of[s] = '0;
			hgt_of[s] = '0;
		end
		pub_slot = '0;
		pub_valid = 1'b0;
		gen_next = PGEN_W'(1);
		last_pub = '0;
		drop_total = '0;
		issued_gen = PGEN_W'(1);
		n_queued = 0;
		bursts = 0;
		mismatches = 0;
		req_taken_total = 0;
		stall_cycles = 0;
		req_xfer = 1'b0;
		fill_directed();
		fill_random();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() > 0 || req_ch.valid)
			@(posedge clk);
		while (due_responses.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_responses.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
